// File: rtl/core/tle_pkg.sv
// Shared widths, types and constants of the tetrahedron Laplace stiffness unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tle_pkg;

  localparam int CoordBits   = 24;
  localparam int EdgeBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * EdgeBits;
  localparam int CrossBits   = ProdBits + 1;
  localparam int CrossLo     = (CrossBits + 1) / 2;
  localparam int CrossHi     = CrossBits - CrossLo;
  localparam int DetBits     = EdgeBits + CrossBits + 2;
  localparam int DenBits     = DetBits + 2;
  localparam int DotBits     = 2 * CrossBits + 2;
  localparam int NumBits     = DotBits + 8;
  localparam int QBits       = 48;
  localparam int ValBits     = 48;
  localparam int InBits      = 12 * CoordBits;
  localparam int InDataBits  = ((InBits + 7) / 8) * 8;
  localparam int OutBits     = 4 + ValBits;
  localparam int OutDataBits = ((OutBits + 7) / 8) * 8;
  localparam int QDepth      = 2;
  localparam int QPtrBits    = 1;

  // One element after the front end: the four cross products and 6*|det|.
  typedef struct packed {
    logic                                  degen;
    logic [DenBits-1:0]                    den;
    logic [3:0][2:0][CrossBits-1:0]        cr;
  } elem_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic       degen;
    logic       last;
    logic       odd;
  } side_t;

  typedef struct packed {
    logic [DenBits-1:0] rem;
    logic [DenBits-1:0] den;
    logic [QBits-1:0]   nlo;
    logic [QBits-1:0]   q;
    logic               neg;
    logic               big;
    side_t              side;
  } div_t;

endpackage

// File: rtl/core/tle_front.sv
// Front end: accepts vertex coordinates and forms cross products and 6*|det|
// in a six-stage pipeline. Depends on tle_pkg.
module tle_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tle_pkg::InDataBits-1:0] in_data_i,
  output logic                          elem_valid_o,
  input  logic                          elem_ready_i,
  output tle_pkg::elem_t                elem_o
);
  import tle_pkg::*;

  logic signed [CoordBits-1:0] p [4][3];
  logic signed [EdgeBits-1:0]  e1_d [4][3], e1_q [4][3], e2_d [4][3], e2_q [4][3];
  logic signed [EdgeBits-1:0]  d3_d [3], d3_q [3], d3b_q [3], d3c_q [3];
  logic signed [ProdBits-1:0]  pa_d [4][3], pa_q [4][3], pb_d [4][3], pb_q [4][3];
  logic signed [CrossBits-1:0] cr_d [4][3], cr3_q [4][3], cr4_q [4][3], cr5_q [4][3];
  logic signed [EdgeBits+CrossLo:0]   plo_d [3], plo_q [3];
  logic signed [EdgeBits+CrossHi-1:0] phi_d [3], phi_q [3];
  logic signed [DetBits-1:0]   det_d, det_q;
  logic [DetBits-1:0]          mag;
  elem_t                       elem_d, elem_q;
  logic [5:0]                  v_d, v_q;
  logic                        adv;

  assign adv          = !v_q[5] || elem_ready_i;
  assign in_ready_o   = adv;
  assign elem_valid_o = v_q[5];
  assign elem_o       = elem_q;
  assign v_d          = {v_q[4:0], in_valid_i};

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int c = 0; c < 3; c++) begin
        p[v][c] = $signed(in_data_i[(3*v+c)*CoordBits +: CoordBits]);
      end
    end
    // Vertex i uses edges from vertex i+1 to vertices i+2 and i+3 (mod 4).
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 3; c++) begin
        e1_d[i][c] = EdgeBits'(p[(i+2)%4][c]) - EdgeBits'(p[(i+1)%4][c]);
        e2_d[i][c] = EdgeBits'(p[(i+3)%4][c]) - EdgeBits'(p[(i+1)%4][c]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      d3_d[c] = EdgeBits'(p[3][c]) - EdgeBits'(p[0][c]);
    end
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 3; c++) begin
        pa_d[i][c] = ProdBits'(e1_q[i][(c+1)%3]) * ProdBits'(e2_q[i][(c+2)%3]);
        pb_d[i][c] = ProdBits'(e1_q[i][(c+2)%3]) * ProdBits'(e2_q[i][(c+1)%3]);
        cr_d[i][c] = CrossBits'(pa_q[i][c]) - CrossBits'(pb_q[i][c]);
      end
    end
    // The determinant is split into low and high partial products.
    for (int c = 0; c < 3; c++) begin
      plo_d[c] = (EdgeBits+CrossLo+1)'(d3c_q[c]) *
                 $signed({1'b0, cr3_q[3][c][CrossLo-1:0]});
      phi_d[c] = (EdgeBits+CrossHi)'(d3c_q[c]) *
                 (EdgeBits+CrossHi)'($signed(cr3_q[3][c][CrossBits-1:CrossLo]));
    end
    det_d = '0;
    for (int c = 0; c < 3; c++) begin
      det_d = det_d + (DetBits'(phi_q[c]) <<< CrossLo) + DetBits'(plo_q[c]);
    end
    mag          = det_q[DetBits-1] ? DetBits'(-det_q) : DetBits'(det_q);
    elem_d.degen = (det_q == '0);
    elem_d.den   = (DenBits'(mag) << 2) + (DenBits'(mag) << 1);
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 3; c++) begin
        elem_d.cr[i][c] = cr5_q[i][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q   <= e1_d;
      e2_q   <= e2_d;
      d3_q   <= d3_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      d3b_q  <= d3_q;
      cr3_q  <= cr_d;
      d3c_q  <= d3b_q;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      cr4_q  <= cr3_q;
      det_q  <= det_d;
      cr5_q  <= cr4_q;
      elem_q <= elem_d;
    end
  end

endmodule

// File: rtl/core/tle_queue.sv
// Two-entry queue of front-end results between the front and back parts.
// Depends on tle_pkg.
module tle_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  tle_pkg::elem_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output tle_pkg::elem_t rd_data_o
);
  import tle_pkg::*;

  elem_t                mem_q [QDepth];
  logic [QPtrBits-1:0]  wptr_d, wptr_q, rptr_d, rptr_q;
  logic [QPtrBits:0]    cnt_d, cnt_q;
  logic                 push, pop;

  assign wr_ready_o = (cnt_q != (QPtrBits+1)'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign wptr_d     = push ? wptr_q + 1'b1 : wptr_q;
  assign rptr_d     = pop ? rptr_q + 1'b1 : rptr_q;
  assign cnt_d      = cnt_q + (QPtrBits+1)'(push) - (QPtrBits+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// File: rtl/core/tle_back.sv
// Back end: walks the sixteen matrix entries of an element, forms each dot
// product and divides by 6*|det| in a pipelined restoring divider. Uses tle_pkg.
module tle_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            elem_valid_i,
  output logic                            elem_ready_o,
  input  tle_pkg::elem_t                  elem_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tle_pkg::OutDataBits-1:0] out_data_o,
  output logic                            out_degen_o,
  output logic                            out_last_o
);
  import tle_pkg::*;

  localparam logic [QBits:0] PosLim = {2'b00, {(QBits-1){1'b1}}};
  localparam logic [QBits:0] NegLim = {2'b01, {(QBits-1){1'b0}}};

  logic                               en, issue;
  logic [3:0]                         k_q, k_d;
  logic [1:0]                         ri, cj;
  logic signed [2*CrossHi-1:0]        hh_d [3], hh_q [3];
  logic signed [CrossBits:0]          hl_d [3], hl_q [3], lh_d [3], lh_q [3];
  logic [2*CrossLo-1:0]               ll_d [3], ll_q [3];
  logic signed [DotBits-1:0]          t_d [3], t_q [3], dot_d, dot_q;
  logic [NumBits-1:0]                 n_d, n_q;
  logic                               neg_d, neg_q;
  logic [DenBits-1:0]                 den_a_q, den_b_q, den_c_q, den_d_q;
  side_t                              side_d, side_a_q, side_b_q, side_c_q, side_d_q;
  logic [DotBits-1:0]                 mag;
  div_t                               dv_d [QBits+1], dv_q [QBits+1];
  logic [DenBits:0]                   sh;
  logic                               ge, rnd;
  logic [QBits:0]                     m_d, m_q, mm;
  logic                               r_neg_q, r_big_q;
  side_t                              r_side_q;
  logic [ValBits-1:0]                 val_d, val_q;
  side_t                              o_side_q;
  logic [QBits+6:0]                   v_d, v_q;

  assign en           = !v_q[QBits+6] || out_ready_i;
  assign issue        = en && elem_valid_i;
  assign elem_ready_o = issue && (k_q == 4'd15);
  assign k_d          = issue ? k_q + 4'd1 : k_q;
  assign ri           = k_q[3:2];
  assign cj           = k_q[1:0];
  assign v_d          = {v_q[QBits+5:0], issue};

  assign out_valid_o  = v_q[QBits+6];
  assign out_data_o   = OutDataBits'({val_q, o_side_q.col, o_side_q.row});
  assign out_degen_o  = o_side_q.degen;
  assign out_last_o   = o_side_q.last;

  always_comb begin
    side_d.row   = ri;
    side_d.col   = cj;
    side_d.degen = elem_i.degen;
    side_d.last  = (k_q == 4'd15);
    side_d.odd   = ri[0] ^ cj[0];
    // Products of split cross-product components, all under 32x32 bits.
    for (int c = 0; c < 3; c++) begin
      hh_d[c] = (2*CrossHi)'($signed(elem_i.cr[ri][c][CrossBits-1:CrossLo])) *
                (2*CrossHi)'($signed(elem_i.cr[cj][c][CrossBits-1:CrossLo]));
      hl_d[c] = (CrossBits+1)'($signed(elem_i.cr[ri][c][CrossBits-1:CrossLo])) *
                $signed({1'b0, elem_i.cr[cj][c][CrossLo-1:0]});
      lh_d[c] = (CrossBits+1)'($signed(elem_i.cr[cj][c][CrossBits-1:CrossLo])) *
                $signed({1'b0, elem_i.cr[ri][c][CrossLo-1:0]});
      ll_d[c] = (2*CrossLo)'(elem_i.cr[ri][c][CrossLo-1:0]) *
                (2*CrossLo)'(elem_i.cr[cj][c][CrossLo-1:0]);
      t_d[c]  = (DotBits'(hh_q[c]) <<< (2*CrossLo)) +
                ((DotBits'(hl_q[c]) + DotBits'(lh_q[c])) <<< CrossLo) +
                $signed(DotBits'(ll_q[c]));
    end
    dot_d = t_q[0] + t_q[1] + t_q[2];
    mag   = dot_q[DotBits-1] ? DotBits'(-dot_q) : DotBits'(dot_q);
    neg_d = dot_q[DotBits-1] ^ side_c_q.odd;
    n_d   = NumBits'(mag) << 8;

    // Entry into the divider: quotients of 2^QBits or more saturate anyway.
    dv_d[0].rem  = DenBits'(n_q >> QBits);
    dv_d[0].den  = den_d_q;
    dv_d[0].nlo  = n_q[QBits-1:0];
    dv_d[0].q    = '0;
    dv_d[0].neg  = neg_q;
    dv_d[0].big  = (n_q >> QBits) >= NumBits'(den_d_q);
    dv_d[0].side = side_d_q;
    sh = '0;
    ge = 1'b0;
    for (int s = 0; s < QBits; s++) begin
      sh             = {dv_q[s].rem, dv_q[s].nlo[QBits-1]};
      ge             = sh >= {1'b0, dv_q[s].den};
      dv_d[s+1]      = dv_q[s];
      dv_d[s+1].rem  = ge ? DenBits'(sh - {1'b0, dv_q[s].den}) : DenBits'(sh);
      dv_d[s+1].nlo  = dv_q[s].nlo << 1;
      dv_d[s+1].q    = {dv_q[s].q[QBits-2:0], ge};
    end
    rnd = {dv_q[QBits].rem, 1'b0} >= {1'b0, dv_q[QBits].den};
    m_d = {1'b0, dv_q[QBits].q} + (QBits+1)'(rnd);

    if (r_neg_q) begin
      mm = (r_big_q || m_q > NegLim) ? NegLim : m_q;
    end else begin
      mm = (r_big_q || m_q > PosLim) ? PosLim : m_q;
    end
    if (r_side_q.degen) begin
      val_d = '0;
    end else if (r_neg_q) begin
      val_d = ValBits'(-mm[QBits-1:0]);
    end else begin
      val_d = mm[ValBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      v_q <= '0;
    end else begin
      k_q <= k_d;
      if (en) begin
        v_q <= v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q     <= hh_d;
      hl_q     <= hl_d;
      lh_q     <= lh_d;
      ll_q     <= ll_d;
      side_a_q <= side_d;
      den_a_q  <= elem_i.den;
      t_q      <= t_d;
      side_b_q <= side_a_q;
      den_b_q  <= den_a_q;
      dot_q    <= dot_d;
      side_c_q <= side_b_q;
      den_c_q  <= den_b_q;
      n_q      <= n_d;
      neg_q    <= neg_d;
      side_d_q <= side_c_q;
      den_d_q  <= den_c_q;
      dv_q     <= dv_d;
      m_q      <= m_d;
      r_neg_q  <= dv_q[QBits].neg;
      r_big_q  <= dv_q[QBits].big;
      r_side_q <= dv_q[QBits].side;
      val_q    <= val_d;
      o_side_q <= r_side_q;
    end
  end

endmodule

// File: rtl/core/tet_laplace_element_stiffness_unit.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: v0_x..v3_z, 24 bits each
// m_axis    out  m_axis_tvalid/tready   tdata: row, col, entry_value; tuser; tlast
//
// The back end walks all sixteen entries of one tetrahedron before it takes
// another and issues one matrix entry per cycle while m_axis does not stall.
// An entry passes 6 front stages, the queue and the back's 48 divider stages.
// Reset clears all valid flags and the entry counter. A stall on m_axis halts
// the back pipeline; the front and its two-entry queue keep accepting until full.
// Depends on tle_pkg, tle_front, tle_queue and tle_back.
module tet_laplace_element_stiffness_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, ..., v3_z from the lowest bit up
  input  logic [tle_pkg::InDataBits-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // row, col, entry_value from the lowest bit up, zero padded
  output logic [tle_pkg::OutDataBits-1:0]  m_axis_tdata,
  // degenerate
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import tle_pkg::*;

  elem_t fe_elem, q_elem;
  logic  fe_valid, fe_ready, q_valid, q_ready;

  tle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .elem_valid_o (fe_valid),
    .elem_ready_i (fe_ready),
    .elem_o       (fe_elem)
  );

  tle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_elem),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_elem)
  );

  tle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_valid_i (q_valid),
    .elem_ready_o (q_ready),
    .elem_i       (q_elem),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_degen_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule
